// File: hdl/p1ts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p1ts_pkg
// Shared types and constants of the P1 triangle stiffness block.
// ----------------------------------------------------------------------------
package p1ts_pkg;

  // Width of one coordinate field and of one matrix entry.
  localparam int unsigned IN_W            = 32;
  localparam int unsigned OUT_W           = 32;
  // Default coordinate width and fraction bits.
  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF   = 16;
  // Unique entries of the symmetric 3x3 matrix.
  localparam int unsigned NUM_ENTRIES     = 6;

  // Entry lanes in output order.
  localparam int unsigned E00 = 0;
  localparam int unsigned E01 = 1;
  localparam int unsigned E02 = 2;
  localparam int unsigned E11 = 3;
  localparam int unsigned E12 = 4;
  localparam int unsigned E22 = 5;

  typedef struct packed {
    logic signed [IN_W-1:0] x_zero;
    logic signed [IN_W-1:0] y_zero;
    logic signed [IN_W-1:0] x_one;
    logic signed [IN_W-1:0] y_one;
    logic signed [IN_W-1:0] x_two;
    logic signed [IN_W-1:0] y_two;
  } tri_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] k_00;
    logic signed [OUT_W-1:0] k_01;
    logic signed [OUT_W-1:0] k_02;
    logic signed [OUT_W-1:0] k_11;
    logic signed [OUT_W-1:0] k_12;
    logic signed [OUT_W-1:0] k_22;
    logic                    degenerate;
    logic                    saturated;
  } tri_out_t;

  // Result of one divider lane.
  typedef struct packed {
    logic signed [OUT_W-1:0] k;
    logic                    sat;
  } entry_t;

endpackage

// File: hdl/p1ts_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p1ts_divider
// Pipelined restoring divider for one matrix entry: one quotient bit per
// stage, followed by saturation to the signed output range and sign restore.
// ----------------------------------------------------------------------------
module p1ts_divider #(
  parameter int unsigned RW = 119
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [RW-1:0]    mag_i,
  input  logic [RW-1:0]    den_i,
  input  logic             neg_i,
  output p1ts_pkg::entry_t res_o
);
  import p1ts_pkg::*;

  localparam int unsigned QB = OUT_W;

  logic [RW-1:0] rem_q [0:QB];
  logic [RW-1:0] den_q [0:QB];
  logic [QB-1:0] quo_q [1:QB+1];
  logic          ovf_q [1:QB+1];
  logic          neg_q [0:QB+1];
  entry_t        res_q;

  // Operand register.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= mag_i;
      den_q[0] <= den_i;
      neg_q[0] <= neg_i;
    end
  end

  // A quotient of 2^32 or more always clips.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[1] <= (rem_q[0] >= (den_q[0] << QB));
      quo_q[1] <= '0;
      rem_q[1] <= rem_q[0];
      den_q[1] <= den_q[0];
      neg_q[1] <= neg_q[0];
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar j = 2; j <= QB + 1; j++) begin : g_bit
    localparam int unsigned BI = QB + 1 - j;
    logic [RW-1:0] shifted;
    logic          ge;

    assign shifted = den_q[j-1] << BI;
    assign ge      = (rem_q[j-1] >= shifted);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[j] <= quo_q[j-1] | ({{(QB-1){1'b0}}, ge} << BI);
        ovf_q[j] <= ovf_q[j-1];
        neg_q[j] <= neg_q[j-1];
      end
    end

    if (j <= QB) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= ge ? (rem_q[j-1] - shifted) : rem_q[j-1];
          den_q[j] <= den_q[j-1];
        end
      end
    end
  end

  // Saturate and restore the sign.
  logic [QB:0]   limit;
  logic          sat;
  logic [QB:0]   kmag;
  logic [QB-1:0] kval;

  always_comb begin
    limit = neg_q[QB+1] ? {2'b01, {(QB-1){1'b0}}} : {2'b00, {(QB-1){1'b1}}};
    sat   = ovf_q[QB+1] || ({1'b0, quo_q[QB+1]} > limit);
    kmag  = sat ? limit : {1'b0, quo_q[QB+1]};
    kval  = neg_q[QB+1] ? (QB'(0) - kmag[QB-1:0]) : kmag[QB-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.k   <= kval;
      res_q.sat <= sat;
    end
  end

  assign res_o = res_q;

endmodule

// File: hdl/p1_triangle_stiffness.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p1_triangle_stiffness
// The pipe is built from the difference, product and numerator stages and
// the 35-stage divider (operand register, overflow check, one quotient bit
// per stage, then saturation).
// Throughput: one triangle per cycle; a stalled output freezes the whole pipe.
// Reset clears only the valid bits; the data path holds no reset.
// Forms the Laplace stiffness matrix of a linear triangle in fixed point.
// ----------------------------------------------------------------------------
module p1_triangle_stiffness #(
  parameter int unsigned COORD_WIDTH = p1ts_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = p1ts_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  p1ts_pkg::tri_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output p1ts_pkg::tri_out_t out_data_o
);
  import p1ts_pkg::*;

  localparam int unsigned CIN     = (COORD_WIDTH < IN_W) ? COORD_WIDTH : IN_W;
  localparam int unsigned DW      = COORD_WIDTH + 2;
  localparam int unsigned PW      = 2 * DW;
  localparam int unsigned SW      = PW + 1;
  localparam int unsigned RW      = SW + FRAC_BITS + OUT_W + 2;
  localparam int unsigned DIV_LAT = OUT_W + 3;
  localparam int unsigned LAT     = DIV_LAT + 3;

  logic en;
  logic vld_q [0:LAT-1];
  logic deg_q [0:DIV_LAT-1];

  // The whole pipe advances unless a finished result is held.
  assign en         = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o = en;

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < LAT; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // Stage 1: edge differences.
  logic signed [DW-1:0] x0e, y0e, x1e, y1e, x2e, y2e;
  logic signed [DW-1:0] a_q, b_q, c_q, d_q, amb_q, cmd_q;

  assign x0e = DW'(signed'(in_data_i.x_zero[CIN-1:0]));
  assign y0e = DW'(signed'(in_data_i.y_zero[CIN-1:0]));
  assign x1e = DW'(signed'(in_data_i.x_one[CIN-1:0]));
  assign y1e = DW'(signed'(in_data_i.y_one[CIN-1:0]));
  assign x2e = DW'(signed'(in_data_i.x_two[CIN-1:0]));
  assign y2e = DW'(signed'(in_data_i.y_two[CIN-1:0]));

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q   <= x1e - x0e;
      b_q   <= x2e - x0e;
      c_q   <= y1e - y0e;
      d_q   <= y2e - y0e;
      amb_q <= x1e - x2e;
      cmd_q <= y1e - y2e;
    end
  end

  // Stage 2: the pairwise products that the determinant and numerators need.
  logic signed [PW-1:0] p_ad_q, p_bc_q, p_bb_q, p_dd_q, p_aa_q, p_cc_q, p_ab_q;
  logic signed [PW-1:0] p_cd_q, p_bm_q, p_dm_q, p_am_q, p_cm_q, p_mm_q, p_nn_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_ad_q <= a_q * d_q;
      p_bc_q <= b_q * c_q;
      p_bb_q <= b_q * b_q;
      p_dd_q <= d_q * d_q;
      p_aa_q <= a_q * a_q;
      p_cc_q <= c_q * c_q;
      p_ab_q <= a_q * b_q;
      p_cd_q <= c_q * d_q;
      p_bm_q <= b_q * amb_q;
      p_dm_q <= d_q * cmd_q;
      p_am_q <= a_q * amb_q;
      p_cm_q <= c_q * cmd_q;
      p_mm_q <= amb_q * amb_q;
      p_nn_q <= cmd_q * cmd_q;
    end
  end

  // Stage 3: determinant and the six exact numerators.
  logic signed [SW-1:0] det_q;
  logic signed [SW-1:0] num_q [0:NUM_ENTRIES-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      det_q      <= SW'(p_ad_q) - SW'(p_bc_q);
      num_q[E00] <= SW'(p_mm_q) + SW'(p_nn_q);
      num_q[E01] <= SW'(p_bm_q) + SW'(p_dm_q);
      num_q[E02] <= SW'(0) - (SW'(p_am_q) + SW'(p_cm_q));
      num_q[E11] <= SW'(p_bb_q) + SW'(p_dd_q);
      num_q[E12] <= SW'(0) - (SW'(p_ab_q) + SW'(p_cd_q));
      num_q[E22] <= SW'(p_aa_q) + SW'(p_cc_q);
    end
  end

  // Divider operands: rounded dividend |n|*2^F + |det| over 2*|det|.
  logic [SW-1:0] dmag;
  logic [RW-1:0] den;
  logic          deg;

  assign dmag = det_q[SW-1] ? (SW'(0) - det_q) : det_q;
  assign den  = RW'(dmag) << 1;
  assign deg  = (det_q == '0);

  always_ff @(posedge clk_i) begin
    if (en) begin
      deg_q[0] <= deg;
      for (int i = 1; i < DIV_LAT; i++) deg_q[i] <= deg_q[i-1];
    end
  end

  entry_t res [0:NUM_ENTRIES-1];

  for (genvar e = 0; e < NUM_ENTRIES; e++) begin : g_lane
    logic [SW-1:0] nmag;
    logic [RW-1:0] mag;

    assign nmag = num_q[e][SW-1] ? (SW'(0) - num_q[e]) : num_q[e];
    assign mag  = (RW'(nmag) << FRAC_BITS) + RW'(dmag);

    p1ts_divider #(
      .RW (RW)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .mag_i (mag),
      .den_i (den),
      .neg_i (num_q[e][SW-1]),
      .res_o (res[e])
    );
  end

  // Result: a degenerate triangle gives zeros and no clipping.
  logic dg;
  assign dg = deg_q[DIV_LAT-1];

  always_comb begin
    out_data_o.k_00       = dg ? '0 : res[E00].k;
    out_data_o.k_01       = dg ? '0 : res[E01].k;
    out_data_o.k_02       = dg ? '0 : res[E02].k;
    out_data_o.k_11       = dg ? '0 : res[E11].k;
    out_data_o.k_12       = dg ? '0 : res[E12].k;
    out_data_o.k_22       = dg ? '0 : res[E22].k;
    out_data_o.degenerate = dg;
    out_data_o.saturated  = !dg && (res[E00].sat || res[E01].sat || res[E02].sat ||
                                    res[E11].sat || res[E12].sat || res[E22].sat);
  end

  assign out_valid_o = vld_q[LAT-1];

  // An empty output slot never blocks the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output slot empty");

  // A degenerate result carries zero K00 and K11 entries and no clipping.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      !out_data_o.saturated && out_data_o.k_00 == '0 && out_data_o.k_11 == '0)
    else $error("degenerate result not cleared");

  // Diagonal entries K11 and K22 are sums of squares and never negative.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !out_data_o.k_11[OUT_W-1] && !out_data_o.k_22[OUT_W-1])
    else $error("negative diagonal entry");

endmodule
